FILE: hdl/multichannel_iir_section_engine_assert.svh
// Assertion macros shared by the IIR section engine RTL.
`ifndef MULTICHANNEL_IIR_SECTION_ENGINE_ASSERT_SVH
`define MULTICHANNEL_IIR_SECTION_ENGINE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked on clk, off during rst.
`define MISE_ASSERT_IMPL(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);
// Next-cycle implication, checked on clk, off during rst.
`define MISE_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define MISE_ASSERT_IMPL(label, pre, post, msg)
`define MISE_ASSERT_NEXT(label, pre, post, msg)
`endif
`endif

FILE: hdl/mise_pkg.sv
// Package: types, constants and saturation helpers of the IIR section engine.
`timescale 1ns / 1ps
`default_nettype none
package mise_pkg;

  localparam int NUM_CHANNELS   = 8;
  localparam int SAMPLE_BITS    = 24;
  localparam int CHANNEL_BITS   = 3;
  localparam int COEF_BITS      = 24;
  localparam int COEF_FRAC_BITS = 20;
  localparam int GAIN_FRAC_BITS = 18;
  localparam int STATE_BITS     = 32;
  localparam int REG_INDEX_BITS = 3;

  // Serial multiply: operand digit width and derived sizes.
  localparam int DIGIT_BITS  = 4;
  localparam int X_DIGITS    = (SAMPLE_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
  localparam int Y_DIGITS    = (STATE_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
  localparam int MAX_DIGITS  = (X_DIGITS > Y_DIGITS) ? X_DIGITS : Y_DIGITS;
  localparam int OPND_BITS   = MAX_DIGITS * DIGIT_BITS;
  localparam int ACC_BITS    = COEF_BITS + DIGIT_BITS + 2;
  localparam int PROD_BITS   = ACC_BITS + OPND_BITS;
  localparam int X_ALIGN     = OPND_BITS - X_DIGITS * DIGIT_BITS;
  localparam int Y_ALIGN     = OPND_BITS - Y_DIGITS * DIGIT_BITS;
  localparam int CNT_BITS    = $clog2(MAX_DIGITS);
  localparam int LANES       = 4;

  localparam int WIDE_BITS = (STATE_BITS > SAMPLE_BITS) ? STATE_BITS : SAMPLE_BITS;
  localparam int MIN_FRAC  = (COEF_FRAC_BITS < GAIN_FRAC_BITS) ? COEF_FRAC_BITS
                                                               : GAIN_FRAC_BITS;
  localparam int SUM_W     = WIDE_BITS + COEF_BITS - MIN_FRAC + 2;

  localparam int MEM_DEPTH = 2 * NUM_CHANNELS;
  localparam int ADDR_BITS = $clog2(MEM_DEPTH);

  localparam logic [COEF_BITS-1:0] WET_RESET = COEF_BITS'(1) << GAIN_FRAC_BITS;

  typedef enum logic [REG_INDEX_BITS-1:0] {
    REG_COEF_A0      = 3'd0,
    REG_COEF_A1      = 3'd1,
    REG_COEF_A2      = 3'd2,
    REG_COEF_B1      = 3'd3,
    REG_COEF_B2      = 3'd4,
    REG_WET_GAIN     = 3'd5,
    REG_DRY_GAIN     = 3'd6,
    REG_TWO_SECTIONS = 3'd7
  } reg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_X,
    ST_SUM_Y,
    ST_MUL_Y,
    ST_FINISH,
    ST_DELIVER
  } state_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] in_sample;
    logic [CHANNEL_BITS-1:0]       channel;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] out_sample;
    logic [CHANNEL_BITS-1:0]       out_channel;
  } out_t;

  typedef struct packed {
    logic step;
    logic top;
  } lane_ctrl_t;

  function automatic logic signed [STATE_BITS-1:0] sat_state(
    input logic signed [SUM_W-1:0] v
  );
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    logic signed [STATE_BITS-1:0] r;
    hi = {{(SUM_W-STATE_BITS+1){1'b0}}, {(STATE_BITS-1){1'b1}}};
    lo = ~hi;
    if (v > hi) begin
      r = hi[STATE_BITS-1:0];
    end else if (v < lo) begin
      r = lo[STATE_BITS-1:0];
    end else begin
      r = v[STATE_BITS-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
    input logic signed [SUM_W-1:0] v
  );
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    logic signed [SAMPLE_BITS-1:0] r;
    hi = {{(SUM_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
    lo = ~hi;
    if (v > hi) begin
      r = hi[SAMPLE_BITS-1:0];
    end else if (v < lo) begin
      r = lo[SAMPLE_BITS-1:0];
    end else begin
      r = v[SAMPLE_BITS-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/multichannel_iir_section_engine.sv
// Top level: multichannel cascaded biquad engine with digit-serial multiply lanes.
//
//  channel  direction  handshake            payload
//  in       into block in_valid / in_stall  in_data   (sample, channel)
//  out      from block out_valid / out_stall out_data (sample, channel)
//  cfg      into block cfg_we               cfg_index, cfg_data
//
// Sequence: each section runs the four multiply lanes over the sample digits (ST_MUL_X),
// forms y (ST_SUM_Y), then takes the state-wide y 4 bits a cycle (ST_MUL_Y) and writes back
// (ST_FINISH); with two sections the second follows. out_valid rises once ST_DELIVER loads
// the result, and the next transaction can be taken in the cycle after the result loads.
// Reset clears control, configuration and the state valid bits, and holds in_stall high.
// A new transaction is taken while the previous result still waits on out_stall.
`timescale 1ns / 1ps
`default_nettype none
`include "multichannel_iir_section_engine_assert.svh"
module multichannel_iir_section_engine (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire logic                                    in_valid,
  output logic                                         in_stall,
  input  wire mise_pkg::in_t                           in_data,
  output logic                                         out_valid,
  input  wire logic                                    out_stall,
  output mise_pkg::out_t                               out_data,
  input  wire logic                                    cfg_we,
  input  wire logic [mise_pkg::REG_INDEX_BITS-1:0]     cfg_index,
  input  wire logic [mise_pkg::COEF_BITS-1:0]          cfg_data
);

  localparam logic [mise_pkg::CNT_BITS-1:0] X_LAST = mise_pkg::CNT_BITS'(mise_pkg::X_DIGITS - 1);
  localparam logic [mise_pkg::CNT_BITS-1:0] Y_LAST = mise_pkg::CNT_BITS'(mise_pkg::Y_DIGITS - 1);
  localparam int SB = mise_pkg::STATE_BITS;
  localparam int SW = mise_pkg::SUM_W;

  // Configuration registers
  logic signed [mise_pkg::COEF_BITS-1:0] coef_a0, coef_a1, coef_a2, coef_b1, coef_b2;
  logic signed [mise_pkg::COEF_BITS-1:0] wet_gain, dry_gain;
  logic                                  two_sections;

  // Control
  mise_pkg::state_t                state, state_next;
  logic [mise_pkg::CNT_BITS-1:0]   cnt;
  logic                            sec;
  logic [mise_pkg::CHANNEL_BITS-1:0] ch;
  logic                            ch_ok;
  logic                            go_second;
  logic                            slot_free;
  mise_pkg::lane_ctrl_t            lane_ctrl;
  logic                            phase_y;
  logic                            mem_we;
  logic                            rd_en;
  logic                            out_load;

  // Datapath
  logic signed [mise_pkg::OPND_BITS-1:0]   opnd;
  logic signed [SW-1:0]                    s1, s2, s3;
  logic signed [mise_pkg::SAMPLE_BITS-1:0] res;
  logic signed [mise_pkg::COEF_BITS-1:0]   lane_coef [mise_pkg::LANES];
  logic signed [mise_pkg::PROD_BITS-1:0]   lane_prod [mise_pkg::LANES];
  logic signed [SW-1:0]                    px0, px1, px2, pdry, pb1, pb2, pwet;
  logic signed [SB-1:0]                    d1, d2, y_val, d1n, d2n;
  logic signed [mise_pkg::SAMPLE_BITS-1:0] o_val;

  // Delay-word store: one entry per section and channel, {d1, d2}
  logic [2*SB-1:0]                   mem [mise_pkg::MEM_DEPTH];
  logic [mise_pkg::MEM_DEPTH-1:0]    vld;
  logic [2*SB-1:0]                   rd_data;
  logic                              rd_vld;
  logic [mise_pkg::ADDR_BITS-1:0]    ra, wa;

  function automatic logic [mise_pkg::ADDR_BITS-1:0] st_addr(
    input logic second,
    input logic [mise_pkg::CHANNEL_BITS-1:0] c
  );
    logic [mise_pkg::ADDR_BITS-1:0] base;
    base = second ? mise_pkg::ADDR_BITS'(mise_pkg::NUM_CHANNELS) : '0;
    return mise_pkg::ADDR_BITS'(c) + base;
  endfunction

  // Configuration writes; unknown indexes fall through the default arm.
  always_ff @(posedge clk) begin
    if (rst) begin
      coef_a0      <= '0;
      coef_a1      <= '0;
      coef_a2      <= '0;
      coef_b1      <= '0;
      coef_b2      <= '0;
      wet_gain     <= mise_pkg::WET_RESET;
      dry_gain     <= '0;
      two_sections <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        mise_pkg::REG_COEF_A0:      coef_a0 <= cfg_data;
        mise_pkg::REG_COEF_A1:      coef_a1 <= cfg_data;
        mise_pkg::REG_COEF_A2:      coef_a2 <= cfg_data;
        mise_pkg::REG_COEF_B1:      coef_b1 <= cfg_data;
        mise_pkg::REG_COEF_B2:      coef_b2 <= cfg_data;
        mise_pkg::REG_WET_GAIN:     wet_gain <= cfg_data;
        mise_pkg::REG_DRY_GAIN:     dry_gain <= cfg_data;
        mise_pkg::REG_TWO_SECTIONS: two_sections <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  assign ch_ok     = (int'(ch) < mise_pkg::NUM_CHANNELS);
  assign go_second = two_sections && !sec && ch_ok;
  assign slot_free = !out_valid || !out_stall;

  // Sequencer: next state and per-state strobes
  always_comb begin
    state_next     = state;
    in_stall       = 1'b1;
    lane_ctrl.step = 1'b0;
    lane_ctrl.top  = 1'b0;
    phase_y        = 1'b0;
    mem_we         = 1'b0;
    rd_en          = 1'b0;
    out_load       = 1'b0;
    case (state)
      mise_pkg::ST_IDLE: begin
        // Hold off the sender while reset is applied.
        in_stall = rst;
        if (in_valid && !rst) begin
          rd_en      = 1'b1;
          state_next = mise_pkg::ST_MUL_X;
        end
      end
      mise_pkg::ST_MUL_X: begin
        lane_ctrl.step = 1'b1;
        lane_ctrl.top  = (cnt == X_LAST);
        if (cnt == X_LAST) begin
          state_next = mise_pkg::ST_SUM_Y;
        end
      end
      mise_pkg::ST_SUM_Y: begin
        state_next = mise_pkg::ST_MUL_Y;
      end
      mise_pkg::ST_MUL_Y: begin
        phase_y        = 1'b1;
        lane_ctrl.step = 1'b1;
        lane_ctrl.top  = (cnt == Y_LAST);
        if (cnt == Y_LAST) begin
          state_next = mise_pkg::ST_FINISH;
        end
      end
      mise_pkg::ST_FINISH: begin
        phase_y = 1'b1;
        mem_we  = ch_ok;
        if (go_second) begin
          rd_en      = 1'b1;
          state_next = mise_pkg::ST_MUL_X;
        end else begin
          state_next = mise_pkg::ST_DELIVER;
        end
      end
      mise_pkg::ST_DELIVER: begin
        if (slot_free) begin
          out_load   = 1'b1;
          state_next = mise_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = mise_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mise_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Lane coefficients: feed-forward and dry gain on the input digits,
  // feedback and wet gain on the section output digits.
  always_comb begin
    if (phase_y) begin
      lane_coef[0] = coef_b1;
      lane_coef[1] = coef_b2;
      lane_coef[2] = wet_gain;
      lane_coef[3] = '0;
    end else begin
      lane_coef[0] = coef_a0;
      lane_coef[1] = coef_a1;
      lane_coef[2] = coef_a2;
      lane_coef[3] = dry_gain;
    end
  end

  for (genvar i = 0; i < mise_pkg::LANES; i++) begin : g_lane
    mise_mac_lane u_lane (
      .clk   (clk),
      .ctrl  (lane_ctrl),
      .coef  (lane_coef[i]),
      .digit (opnd[mise_pkg::DIGIT_BITS-1:0]),
      .prod  (lane_prod[i])
    );
  end

  // Align the finished products and drop the fraction (floor by arithmetic shift).
  assign px0  = SW'(lane_prod[0] >>> (mise_pkg::X_ALIGN + mise_pkg::COEF_FRAC_BITS));
  assign px1  = SW'(lane_prod[1] >>> (mise_pkg::X_ALIGN + mise_pkg::COEF_FRAC_BITS));
  assign px2  = SW'(lane_prod[2] >>> (mise_pkg::X_ALIGN + mise_pkg::COEF_FRAC_BITS));
  assign pdry = SW'(lane_prod[3] >>> (mise_pkg::X_ALIGN + mise_pkg::GAIN_FRAC_BITS));
  assign pb1  = SW'(lane_prod[0] >>> (mise_pkg::Y_ALIGN + mise_pkg::COEF_FRAC_BITS));
  assign pb2  = SW'(lane_prod[1] >>> (mise_pkg::Y_ALIGN + mise_pkg::COEF_FRAC_BITS));
  assign pwet = SW'(lane_prod[2] >>> (mise_pkg::Y_ALIGN + mise_pkg::GAIN_FRAC_BITS));

  // Entries never written read as zero.
  assign d1 = rd_vld ? rd_data[2*SB-1:SB] : '0;
  assign d2 = rd_vld ? rd_data[SB-1:0]    : '0;

  assign y_val = mise_pkg::sat_state(px0 + SW'(d1));
  assign d1n   = mise_pkg::sat_state(s1 - pb1);
  assign d2n   = mise_pkg::sat_state(s2 - pb2);
  assign o_val = mise_pkg::sat_sample(s3 + pwet);

  assign ra = (state == mise_pkg::ST_IDLE) ? st_addr(1'b0, in_data.channel)
                                           : st_addr(1'b1, ch);
  assign wa = st_addr(sec, ch);

  // Delay-word memory: registered read, single write port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wa] <= {d1n, d2n};
    end
    if (rd_en) begin
      rd_data <= mem[ra];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (mem_we) begin
        vld[wa] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld <= vld[ra];
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      mise_pkg::ST_IDLE: begin
        // Latch the transaction and load the sample as the serial operand.
        if (in_valid) begin
          opnd <= mise_pkg::OPND_BITS'(in_data.in_sample);
          ch   <= in_data.channel;
          sec  <= 1'b0;
          cnt  <= '0;
        end
      end
      mise_pkg::ST_MUL_X, mise_pkg::ST_MUL_Y: begin
        // Advance one digit.
        opnd <= opnd >>> mise_pkg::DIGIT_BITS;
        cnt  <= lane_ctrl.top ? '0 : cnt + 1'b1;
      end
      mise_pkg::ST_SUM_Y: begin
        // Form y, hold the input-side partial sums, and serialize y next.
        opnd <= mise_pkg::OPND_BITS'(y_val);
        s1   <= px1 + SW'(d2);
        s2   <= px2;
        s3   <= pdry;
      end
      mise_pkg::ST_FINISH: begin
        // Out-of-range channels give a zero sample.
        res <= ch_ok ? o_val : '0;
        if (go_second) begin
          opnd <= mise_pkg::OPND_BITS'(o_val);
          sec  <= 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Output register: load when free, drop valid once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.out_sample  <= res;
      out_data.out_channel <= ch;
    end
  end

  `MISE_ASSERT_NEXT(a_accept_starts, in_valid && !in_stall, state == mise_pkg::ST_MUL_X && !sec, "accepted transaction did not start the first section")
  `MISE_ASSERT_IMPL(a_write_in_finish, mem_we, state == mise_pkg::ST_FINISH && ch_ok, "state write outside the finish step")
  `MISE_ASSERT_IMPL(a_cascade_enabled, state == mise_pkg::ST_FINISH && sec, two_sections, "second section ran with cascade off")
  `MISE_ASSERT_IMPL(a_result_from_deliver, $rose(out_valid), $past(state) == mise_pkg::ST_DELIVER, "result loaded outside delivery")
  `MISE_ASSERT_IMPL(a_digit_count, state == mise_pkg::ST_MUL_X, cnt <= X_LAST, "sample digit count overran")

endmodule
`default_nettype wire

FILE: hdl/mise_mac_lane.sv
// Digit-serial multiply lane: parallel coefficient times a serial operand.
`timescale 1ns / 1ps
`default_nettype none
module mise_mac_lane (
  input  wire logic                                   clk,
  input  wire mise_pkg::lane_ctrl_t                   ctrl,
  input  wire logic signed [mise_pkg::COEF_BITS-1:0]  coef,
  input  wire logic [mise_pkg::DIGIT_BITS-1:0]        digit,
  output logic signed [mise_pkg::PROD_BITS-1:0]       prod
);

  logic signed [mise_pkg::ACC_BITS-1:0] acc;
  logic signed [mise_pkg::ACC_BITS-1:0] t;
  logic [mise_pkg::OPND_BITS-1:0]       low;
  logic signed [mise_pkg::DIGIT_BITS:0] dsig;
  logic signed [mise_pkg::COEF_BITS+mise_pkg::DIGIT_BITS:0] pp;

  // The top digit carries the operand sign and weighs negative.
  always_comb begin
    dsig = ctrl.top ? {digit[mise_pkg::DIGIT_BITS-1], digit} : {1'b0, digit};
    pp   = coef * dsig;
    t    = acc + mise_pkg::ACC_BITS'(pp);
  end

  // Retire one digit of product per cycle into the low word while stepping; clear when idle.
  always_ff @(posedge clk) begin
    if (ctrl.step) begin
      acc <= t >>> mise_pkg::DIGIT_BITS;
      low <= {t[mise_pkg::DIGIT_BITS-1:0], low[mise_pkg::OPND_BITS-1:mise_pkg::DIGIT_BITS]};
    end else begin
      acc <= '0;
      low <= '0;
    end
  end

  assign prod = $signed({acc, low});

endmodule
`default_nettype wire
